// ===== rtl/i2csbs_pkg.sv =====
`timescale 1ns / 1ps
package i2csbs_pkg;

    localparam int DATA_W  = 8;
    localparam int INDEX_W = 3;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        KIND_START    = 2'd0,
        KIND_OVERFLOW = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_LOAD     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_CHECK_ADDRESS = 3'd1,
        PH_SEND_DATA     = 3'd2,
        PH_REQ_REPLY     = 3'd3,
        PH_CHECK_REPLY   = 3'd4,
        PH_REQ_DATA      = 3'd5,
        PH_GET_DATA      = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ACT_RELEASE   = 3'd0,
        ACT_SEND_ACK  = 3'd1,
        ACT_SEND_DATA = 3'd2,
        ACT_READ_ACK  = 3'd3,
        ACT_READ_DATA = 3'd4,
        ACT_RECV_ADDR = 3'd5,
        ACT_NONE      = 3'd6
    } act_t;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

    localparam logic [DATA_W-1:0] OWN_ADDRESS_RESET   = 8'h00;
    localparam logic [DATA_W-1:0] TIMEOUT_TICKS_RESET = 8'h08;
    localparam logic [DATA_W-1:0] ADDR_MASK           = 8'hFE;
    localparam logic [DATA_W-1:0] GENERAL_CALL        = 8'h00;

    typedef struct packed {
        act_t              action;
        logic              send;
        logic              rx_valid;
        logic [DATA_W-1:0] rx_byte;
    } res_t;

endpackage

// ===== rtl/i2csbs_in_if.sv =====
`timescale 1ns / 1ps
interface i2csbs_in_if;
    import i2csbs_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [DATA_W-1:0]  shift_byte;
    logic               stop_seen;
    logic [INDEX_W-1:0] reply_index;
    logic [DATA_W-1:0]  reply_value;

    modport source (
        output valid, kind, shift_byte, stop_seen, reply_index, reply_value,
        input  ready
    );
    modport sink (
        input  valid, kind, shift_byte, stop_seen, reply_index, reply_value,
        output ready
    );
endinterface

// ===== rtl/i2csbs_out_if.sv =====
`timescale 1ns / 1ps
interface i2csbs_out_if;
    import i2csbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [DATA_W-1:0] tx_byte;
    logic              rx_valid;
    logic [DATA_W-1:0] rx_byte;

    modport source (
        output valid, action, tx_byte, rx_valid, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, action, tx_byte, rx_valid, rx_byte,
        output ready
    );
endinterface

// ===== rtl/i2csbs_reply_mem.sv =====
`timescale 1ns / 1ps
module i2csbs_reply_mem
    import i2csbs_pkg::*;
#(
    parameter int DEPTH = 6,
    parameter int AW    = 3
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // entries never loaded read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/i2csbs_ctrl.sv =====
`timescale 1ns / 1ps
module i2csbs_ctrl
    import i2csbs_pkg::*;
#(
    parameter int DEPTH = 6,
    parameter int AW    = 3
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 accept,
    input  logic [1:0]           kind,
    input  logic [DATA_W-1:0]    shift_byte,
    input  logic                 stop_seen,
    input  logic [INDEX_W-1:0]   reply_index,
    input  logic [DATA_W-1:0]    reply_value,
    output res_t                 res,
    output logic [AW-1:0]        rd_addr,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [DATA_W-1:0]    wr_data
);

    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    phase_t            phase_reg, phase_next;
    logic [AW-1:0]     pointer_reg, pointer_next;
    logic              written_reg, written_next;
    logic              running_reg, running_next;
    logic [DATA_W-1:0] ticks_reg, ticks_next;
    logic [DATA_W-1:0] own_address_reg;
    logic [DATA_W-1:0] timeout_reg;
    logic [DATA_W-1:0] tick_inc;
    kind_t             kind_cur;

    assign kind_cur = kind_t'(kind);
    assign tick_inc = ticks_reg + 1'b1;
    assign rd_addr  = pointer_reg;
    assign wr_addr  = AW'(reply_index);
    assign wr_data  = reply_value;
    assign wr_en    = accept && (kind_cur == KIND_LOAD) && (int'(reply_index) < DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= OWN_ADDRESS_RESET;
            timeout_reg     <= TIMEOUT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS:   own_address_reg <= cfg_data;
                CFG_TIMEOUT_TICKS: timeout_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pointer_reg <= '0;
            written_reg <= 1'b0;
            running_reg <= 1'b0;
            ticks_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pointer_reg <= pointer_next;
            written_reg <= written_next;
            running_reg <= running_next;
            ticks_reg   <= ticks_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        pointer_next = pointer_reg;
        written_next = written_reg;
        running_next = running_reg;
        ticks_next   = ticks_reg;
        res          = '{action: ACT_NONE, send: 1'b0, rx_valid: 1'b0, rx_byte: '0};
        if (accept)
        begin
            case (kind_cur)
                KIND_START:
                begin
                    ticks_next   = '0;
                    running_next = 1'b1;
                    if (stop_seen)
                    begin
                        phase_next = PH_IDLE;
                        res.action = ACT_RELEASE;
                    end
                    else
                    begin
                        phase_next = PH_CHECK_ADDRESS;
                        res.action = ACT_RECV_ADDR;
                    end
                end
                KIND_OVERFLOW:
                begin
                    case (phase_reg)
                        PH_CHECK_ADDRESS:
                        begin
                            if (shift_byte == GENERAL_CALL
                                || (shift_byte & ADDR_MASK) == own_address_reg)
                            begin
                                if (shift_byte[0])
                                begin
                                    phase_next   = PH_SEND_DATA;
                                    pointer_next = '0;
                                end
                                else
                                begin
                                    phase_next   = PH_REQ_DATA;
                                    written_next = 1'b0;
                                end
                                res.action = ACT_SEND_ACK;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                res.action = ACT_RELEASE;
                            end
                        end
                        PH_SEND_DATA, PH_CHECK_REPLY:
                        begin
                            if (phase_reg == PH_CHECK_REPLY && shift_byte != '0)
                            begin
                                phase_next = PH_IDLE;
                                res.action = ACT_RELEASE;
                            end
                            else
                            begin
                                // send current entry, advance around the ring
                                res.action   = ACT_SEND_DATA;
                                res.send     = 1'b1;
                                phase_next   = PH_REQ_REPLY;
                                pointer_next = (pointer_reg == LAST_PTR) ? '0
                                                                         : pointer_reg + 1'b1;
                            end
                        end
                        PH_REQ_REPLY:
                        begin
                            phase_next = PH_CHECK_REPLY;
                            res.action = ACT_READ_ACK;
                        end
                        PH_REQ_DATA:
                        begin
                            if (written_reg)
                            begin
                                phase_next = PH_IDLE;
                                res.action = ACT_RELEASE;
                            end
                            else
                            begin
                                phase_next = PH_GET_DATA;
                                res.action = ACT_READ_DATA;
                            end
                        end
                        PH_GET_DATA:
                        begin
                            written_next = 1'b1;
                            res.rx_valid = 1'b1;
                            res.rx_byte  = shift_byte;
                            phase_next   = PH_REQ_DATA;
                            res.action   = ACT_SEND_ACK;
                        end
                        default:
                        begin
                            res.action = ACT_NONE;
                        end
                    endcase
                end
                KIND_TICK:
                begin
                    if (running_reg)
                    begin
                        if (tick_inc == timeout_reg)
                        begin
                            running_next = 1'b0;
                            ticks_next   = '0;
                            phase_next   = PH_IDLE;
                            res.action   = ACT_RELEASE;
                        end
                        else
                        begin
                            ticks_next = tick_inc;
                        end
                    end
                end
                default:
                begin
                    res.action = ACT_NONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/i2csbs_top_dummy_placeholder_never.sv =====
`timescale 1ns / 1ps
module i2csbs_result_reg
    import i2csbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              take,
    input  res_t              res,
    input  logic [DATA_W-1:0] mem_data,
    output logic              valid,
    output logic [2:0]        action,
    output logic [DATA_W-1:0] tx_byte,
    output logic              rx_valid,
    output logic [DATA_W-1:0] rx_byte
);

    logic valid_reg;
    res_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign valid    = valid_reg;
    assign action   = res_reg.action;
    assign tx_byte  = res_reg.send ? mem_data : '0;
    assign rx_valid = res_reg.rx_valid;
    assign rx_byte  = res_reg.rx_byte;

endmodule

// ===== rtl/i2c_slave_byte_sequencer_top.sv =====
`timescale 1ns / 1ps
// Byte-level I2C slave sequencer. One event is taken every clock cycle unless
// the sink stalls, and its result appears in the output register in the cycle
// after; the output register holds while the sink stalls, and a new event is
// taken in the same cycle the held result is taken. The transmit byte comes
// from the reply memory's synchronous read port, read for every event at the
// current reply pointer. Never-loaded reply entries read as zero through
// per-entry written flags cleared by reset, so there is no clearing pass after
// reset. Configuration registers are to be written through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce it.
module i2c_slave_byte_sequencer_top
    import i2csbs_pkg::*;
#(
    parameter int REPLY_LENGTH = 6
)(
    input  logic                 clk,
    input  logic                 rst_n,
    i2csbs_in_if.sink            in_ch,
    i2csbs_out_if.source         out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int AW = (REPLY_LENGTH > 1) ? $clog2(REPLY_LENGTH) : 1;

    logic              accept;
    logic              out_valid;
    res_t              res;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] mem_data;

    assign in_ch.ready = !out_valid || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    i2csbs_ctrl #(
        .DEPTH (REPLY_LENGTH),
        .AW    (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .kind        (in_ch.kind),
        .shift_byte  (in_ch.shift_byte),
        .stop_seen   (in_ch.stop_seen),
        .reply_index (in_ch.reply_index),
        .reply_value (in_ch.reply_value),
        .res         (res),
        .rd_addr     (rd_addr),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    i2csbs_reply_mem #(
        .DEPTH (REPLY_LENGTH),
        .AW    (AW)
    ) u_reply_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mem_data)
    );

    i2csbs_result_reg u_result_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .take     (out_ch.ready),
        .res      (res),
        .mem_data (mem_data),
        .valid    (out_valid),
        .action   (out_ch.action),
        .tx_byte  (out_ch.tx_byte),
        .rx_valid (out_ch.rx_valid),
        .rx_byte  (out_ch.rx_byte)
    );

    assign out_ch.valid = out_valid;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import i2csbs_pkg::*;

    localparam int REPLY_LEN   = 6;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        kind_t              kind;
        logic [DATA_W-1:0]  shift_byte;
        logic               stop_seen;
        logic [INDEX_W-1:0] reply_index;
        logic [DATA_W-1:0]  reply_value;
    } bus_event_t;

    typedef struct packed {
        act_t              action;
        logic [DATA_W-1:0] tx_byte;
        logic              rx_valid;
        logic [DATA_W-1:0] rx_byte;
    } seq_result_t;

    typedef struct packed {
        kind_t              kind;
        logic [DATA_W-1:0]  shift_byte;
        logic               stop_seen;
        logic [INDEX_W-1:0] reply_index;
        logic [DATA_W-1:0]  reply_value;
        logic               typed;
        act_t               action;
        logic [DATA_W-1:0]  tx_byte;
        logic               rx_valid;
        logic [DATA_W-1:0]  rx_byte;
    } stim_row_t;

    localparam seq_result_t NO_RESULT = '{ACT_NONE, 8'h00, 1'b0, 8'h00};

    // Rows with typed = 0 take their expectation from the predictor.
    localparam stim_row_t DIRECTED_ROWS [29] = '{
        // kind        byte   stop  idx   value  typed action         tx     rxv   rx
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'hFF, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_LOAD,     8'h00, 1'b0, 3'd0, 8'hFF, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_LOAD,     8'h00, 1'b0, 3'd5, 8'h5A, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_LOAD,     8'h00, 1'b1, 3'd7, 8'h33, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_START,    8'h00, 1'b1, 3'd0, 8'h00, 1'b1, ACT_RELEASE,   8'h00, 1'b0, 8'h00},
        '{KIND_START,    8'hFF, 1'b0, 3'd7, 8'hFF, 1'b1, ACT_RECV_ADDR, 8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'h01, 1'b0, 3'd0, 8'h00, 1'b0, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'h00, 1'b0, 3'd0, 8'h00, 1'b0, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'h00, 1'b0, 3'd0, 8'h00, 1'b0, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'h00, 1'b0, 3'd0, 8'h00, 1'b0, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'h00, 1'b0, 3'd0, 8'h00, 1'b0, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'h80, 1'b0, 3'd0, 8'h00, 1'b1, ACT_RELEASE,   8'h00, 1'b0, 8'h00},
        '{KIND_START,    8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_RECV_ADDR, 8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'h00, 1'b0, 3'd0, 8'h00, 1'b0, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'h00, 1'b0, 3'd0, 8'h00, 1'b0, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'hFF, 1'b0, 3'd0, 8'h00, 1'b0, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_RELEASE,   8'h00, 1'b0, 8'h00},
        '{KIND_START,    8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_RECV_ADDR, 8'h00, 1'b0, 8'h00},
        '{KIND_OVERFLOW, 8'hA4, 1'b0, 3'd0, 8'h00, 1'b1, ACT_RELEASE,   8'h00, 1'b0, 8'h00},
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00},
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_RELEASE,   8'h00, 1'b0, 8'h00},
        '{KIND_TICK,     8'h00, 1'b0, 3'd0, 8'h00, 1'b1, ACT_NONE,      8'h00, 1'b0, 8'h00}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    i2csbs_in_if  in_ch();
    i2csbs_out_if out_ch();

    i2c_slave_byte_sequencer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state and its copy of the registers
    logic [DATA_W-1:0] match_addr;
    logic [DATA_W-1:0] tick_limit;
    phase_t            bus_phase;
    int                reply_ptr;
    logic              byte_taken;
    logic              timer_on;
    logic [DATA_W-1:0] tick_cnt;
    logic [DATA_W-1:0] reply_mem [REPLY_LEN];

    seq_result_t expected_results [$];
    int          idle_pct;
    int          events_sent;
    int          results_checked;
    int          error_count;
    int          timeouts_seen;
    int          bytes_sent;
    int          bytes_received;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic seq_result_t sequencer_next(input bus_event_t ev);
        seq_result_t r;
        r = NO_RESULT;
        case (ev.kind)
            KIND_START:
            begin
                tick_cnt = '0;
                timer_on = 1'b1;
                if (ev.stop_seen)
                begin
                    bus_phase = PH_IDLE;
                    r.action  = ACT_RELEASE;
                end
                else
                begin
                    bus_phase = PH_CHECK_ADDRESS;
                    r.action  = ACT_RECV_ADDR;
                end
            end
            KIND_OVERFLOW:
            begin
                case (bus_phase)
                    PH_CHECK_ADDRESS:
                    begin
                        if (ev.shift_byte == GENERAL_CALL ||
                            (ev.shift_byte & ADDR_MASK) == match_addr)
                        begin
                            if (ev.shift_byte[0])
                            begin
                                bus_phase = PH_SEND_DATA;
                                reply_ptr = 0;
                            end
                            else
                            begin
                                bus_phase  = PH_REQ_DATA;
                                byte_taken = 1'b0;
                            end
                            r.action = ACT_SEND_ACK;
                        end
                        else
                        begin
                            bus_phase = PH_IDLE;
                            r.action  = ACT_RELEASE;
                        end
                    end
                    PH_CHECK_REPLY, PH_SEND_DATA:
                    begin
                        // a nonzero ack bit is a NACK from the master
                        if (bus_phase == PH_CHECK_REPLY && ev.shift_byte != '0)
                        begin
                            bus_phase = PH_IDLE;
                            r.action  = ACT_RELEASE;
                        end
                        else
                        begin
                            r.action  = ACT_SEND_DATA;
                            r.tx_byte = reply_mem[reply_ptr];
                            reply_ptr = (reply_ptr == REPLY_LEN - 1) ? 0 : reply_ptr + 1;
                            bus_phase = PH_REQ_REPLY;
                            bytes_sent++;
                        end
                    end
                    PH_REQ_REPLY:
                    begin
                        bus_phase = PH_CHECK_REPLY;
                        r.action  = ACT_READ_ACK;
                    end
                    PH_REQ_DATA:
                    begin
                        if (byte_taken)
                        begin
                            bus_phase = PH_IDLE;
                            r.action  = ACT_RELEASE;
                        end
                        else
                        begin
                            bus_phase = PH_GET_DATA;
                            r.action  = ACT_READ_DATA;
                        end
                    end
                    PH_GET_DATA:
                    begin
                        byte_taken = 1'b1;
                        r.rx_valid = 1'b1;
                        r.rx_byte  = ev.shift_byte;
                        bus_phase  = PH_REQ_DATA;
                        r.action   = ACT_SEND_ACK;
                        bytes_received++;
                    end
                    default:
                        r.action = ACT_NONE;
                endcase
            end
            KIND_TICK:
            begin
                if (timer_on)
                begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt == tick_limit)
                    begin
                        timer_on  = 1'b0;
                        tick_cnt  = '0;
                        bus_phase = PH_IDLE;
                        r.action  = ACT_RELEASE;
                        timeouts_seen++;
                    end
                end
            end
            default:
            begin
                if (ev.reply_index < REPLY_LEN)
                    reply_mem[ev.reply_index] = ev.reply_value;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        error_count++;
        $display("mismatch at %0t, result %0d: %s got 0x%0h, want 0x%0h",
                 $time, results_checked, field, got, want);
    endtask

    task automatic send_event(input bus_event_t ev, input logic typed,
                              input seq_result_t typed_res);
        seq_result_t predicted;
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= ev.kind;
        in_ch.shift_byte  <= ev.shift_byte;
        in_ch.stop_seen   <= ev.stop_seen;
        in_ch.reply_index <= ev.reply_index;
        in_ch.reply_value <= ev.reply_value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = sequencer_next(ev);
        expected_results.push_back(typed ? typed_res : predicted);
        events_sent++;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic post(input bus_event_t ev);
        send_event(ev, 1'b0, NO_RESULT);
    endtask

    function automatic bus_event_t random_event(input kind_t k);
        bus_event_t ev;
        ev.kind        = k;
        ev.shift_byte  = 8'($urandom);
        ev.stop_seen   = 1'($urandom);
        ev.reply_index = 3'($urandom);
        ev.reply_value = 8'($urandom);
        return ev;
    endfunction

    function automatic bus_event_t overflow_with(input logic [DATA_W-1:0] b);
        bus_event_t ev;
        ev            = random_event(KIND_OVERFLOW);
        ev.shift_byte = b;
        return ev;
    endfunction

    function automatic logic [DATA_W-1:0] pick_address(input logic rd);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return match_addr | rd;
        else if (pick < 8)
            return GENERAL_CALL | rd;
        return 8'($urandom);
    endfunction

    task automatic send_start();
        bus_event_t ev;
        ev           = random_event(KIND_START);
        ev.stop_seen = ($urandom_range(0, 19) == 0);
        post(ev);
    endtask

    // Drop a stray tick or reply load into a transfer now and then
    task automatic maybe_interject();
        if ($urandom_range(0, 11) == 0)
            post(random_event($urandom_range(0, 1) ? KIND_TICK : KIND_LOAD));
    endtask

    task automatic read_transfer();
        int n_bytes;
        int i;
        n_bytes = $urandom_range(1, 8);
        send_start();
        post(overflow_with(pick_address(1'b1)));
        maybe_interject();
        post(random_event(KIND_OVERFLOW));
        for (i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                break;
            maybe_interject();
            post(random_event(KIND_OVERFLOW));
            // ack every byte but the last
            post(overflow_with(i == n_bytes - 1 ? 8'($urandom_range(1, 255)) : 8'h00));
        end
    endtask

    task automatic write_transfer();
        send_start();
        post(overflow_with(pick_address(1'b0)));
        maybe_interject();
        post(random_event(KIND_OVERFLOW));
        post(random_event(KIND_OVERFLOW));
        if ($urandom_range(0, 3) != 0)
            post(random_event(KIND_OVERFLOW));
    endtask

    task automatic tick_burst();
        int n;
        n = $urandom_range(1, (tick_limit < 15) ? int'(tick_limit) + 1 : 16);
        repeat (n) post(random_event(KIND_TICK));
    endtask

    task automatic run_traffic(input int n_items);
        int stop_at;
        int pick;
        stop_at = events_sent + n_items;
        while (events_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                read_transfer();
            else if (pick < 70)
                write_transfer();
            else if (pick < 80)
                post(random_event(KIND_LOAD));
            else if (pick < 90)
                tick_burst();
            else
                post(random_event(kind_t'($urandom_range(0, 3))));
        end
    endtask

    // Drain every outstanding result, then allow for the output register
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic configure(input logic [DATA_W-1:0] addr, input logic [DATA_W-1:0] ticks);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OWN_ADDRESS;
        cfg_data  <= addr;
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_data  <= ticks;
        @(posedge clk);
        cfg_we     <= 1'b0;
        match_addr = addr;
        tick_limit = ticks;
    endtask

    initial
    begin
        int          stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    stall_left = $urandom_range(1, 9);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        seq_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result, action", out_ch.action, ACT_NONE);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.action !== want.action)
                    report_mismatch("action", out_ch.action, want.action);
                if (out_ch.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", out_ch.tx_byte, want.tx_byte);
                if (out_ch.rx_valid !== want.rx_valid)
                    report_mismatch("rx_valid", out_ch.rx_valid, want.rx_valid);
                if (out_ch.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", out_ch.rx_byte, want.rx_byte);
                results_checked++;
            end
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        bus_event_t  ev;
        seq_result_t res;
        stim_row_t   row;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = '0;
        in_ch.shift_byte  = '0;
        in_ch.stop_seen   = 1'b0;
        in_ch.reply_index = '0;
        in_ch.reply_value = '0;
        idle_pct          = 20;
        events_sent       = 0;
        results_checked   = 0;
        error_count       = 0;
        timeouts_seen     = 0;
        bytes_sent        = 0;
        bytes_received    = 0;
        match_addr        = OWN_ADDRESS_RESET;
        tick_limit        = TIMEOUT_TICKS_RESET;
        bus_phase         = PH_IDLE;
        reply_ptr         = 0;
        byte_taken        = 1'b0;
        timer_on          = 1'b0;
        tick_cnt          = '0;
        foreach (reply_mem[i])
            reply_mem[i] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[r])
        begin
            row = DIRECTED_ROWS[r];
            ev  = '{row.kind, row.shift_byte, row.stop_seen, row.reply_index, row.reply_value};
            res = '{row.action, row.tx_byte, row.rx_valid, row.rx_byte};
            send_event(ev, row.typed, res);
        end

        settle();
        configure(8'h5A, 8'd255);
        idle_pct = 30;
        run_traffic(30);
        // hold the timer long enough to reach the largest timeout
        ev           = random_event(KIND_START);
        ev.stop_seen = 1'b0;
        post(ev);
        repeat (255) post(random_event(KIND_TICK));

        settle();
        configure(8'hFE, 8'd1);
        idle_pct = 0;
        run_traffic(80);

        settle();
        configure(8'h36, 8'd3);
        idle_pct = 40;
        run_traffic(80);

        settle();
        configure(8'hA4, 8'd12);
        idle_pct = 0;
        run_traffic(60);

        settle();
        $display("summary: %0d events (%0d directed) under five register settings, %0d results",
                 events_sent, $size(DIRECTED_ROWS), results_checked);
        $display("summary: %0d reply bytes sent, %0d bytes received, %0d timeouts, %0d mismatches",
                 bytes_sent, bytes_received, timeouts_seen, error_count);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/i2csbs_pkg.sv
rtl/i2csbs_in_if.sv
rtl/i2csbs_out_if.sv
rtl/i2csbs_reply_mem.sv
rtl/i2csbs_ctrl.sv
rtl/i2csbs_top_dummy_placeholder_never.sv
rtl/i2c_slave_byte_sequencer_top.sv
sim/testbench.sv
